>>> sv/hsxfp_pkg.sv
// Shared types and constants for the header synced XOR frame parser.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
package hsxfp_pkg;

   localparam int BYTE_W        = 8;
   localparam int POS_W         = 4;
   localparam int PAYLOAD_BYTES = 7;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
   localparam int SLOT_W        = 3;
   localparam int COUNT_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;
   localparam int QUEUE_DEPTH   = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_BYTE     = 2'd2;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'h55;
   localparam logic [BYTE_W-1:0] TAIL_BYTE_RESET     = 8'h00;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_TAIL_BAD = 2'd1,
      STATUS_XOR_BAD  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FS_HUNT = 3'b001,
      FS_SYNC = 3'b010,
      FS_BODY = 3'b100
   } frame_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] tail_byte;
   } cfg_type;

   // One classified frame on its way from the front to the back.
   typedef struct packed {
      status_type           status;
      logic [PAYLOAD_W-1:0] payload;
   } frame_entry_type;

endpackage

>>> sv/hsxfp_req_if.sv
// Byte channel into the parser: valid, ready and one received byte.
// Depends on hsxfp_pkg for the byte width.
`timescale 1ns / 1ps
interface hsxfp_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsxfp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> sv/hsxfp_rsp_if.sv
// Result channel out of the parser: status, payload and frame counters.
// Depends on hsxfp_pkg for the field widths.
`timescale 1ns / 1ps
interface hsxfp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsxfp_pkg::STATUS_W-1:0]  status;
   logic [hsxfp_pkg::PAYLOAD_W-1:0] payload;
   logic [hsxfp_pkg::COUNT_W-1:0]   good_frames;
   logic [hsxfp_pkg::COUNT_W-1:0]   dropped_frames;

   modport source (output valid, output status, output payload, output good_frames,
                   output dropped_frames, input ready);
   modport sink   (input valid, input status, input payload, input good_frames,
                   input dropped_frames, output ready);
endinterface

>>> sv/header_synced_xor_frame_parser_unit.sv
// Top level of the header synced XOR frame parser: registers, front, queue, back.
// Depends on hsxfp_pkg, hsxfp_req_if, hsxfp_rsp_if, hsxfp_front, hsxfp_queue, hsxfp_back.
//
//   Channel   Direction  Beat carries
//   req_chan  in         rx_byte, one received serial byte
//   rsp_chan  out        status, payload, good_frames, dropped_frames
//   csr_*     in         write enable, register index, 8-bit data
//
// One byte is accepted per cycle while req_chan.ready is high. A result beat shows
// on rsp_chan after the last byte of a frame, through the frame queue and into the output
// register. The frame queue holds two classified frames; req_chan.ready falls only
// when it is full, which takes a result beat held in the output register by a
// rsp_chan stall with two more completed frames queued behind it.
// Synchronous reset returns the hunt, queue, counters and registers to their reset values.
`timescale 1ns / 1ps
module header_synced_xor_frame_parser_unit #(
   parameter int FRAME_BYTES = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   hsxfp_req_if.sink                           req_chan,
   hsxfp_rsp_if.source                         rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [hsxfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hsxfp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hsxfp_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            push;
   logic            pop;
   logic            queue_full;
   logic            queue_empty;
   frame_entry_type push_entry;
   frame_entry_type head;

   // Configuration registers; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER_FIRST:  cfg_in.header_first  = csr_wdata;
            CSR_HEADER_SECOND: cfg_in.header_second = csr_wdata;
            CSR_TAIL_BYTE:     cfg_in.tail_byte     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= HEADER_FIRST_RESET;
         cfg_ff.header_second <= HEADER_SECOND_RESET;
         cfg_ff.tail_byte     <= TAIL_BYTE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end hunts for the header, collects the frame and classifies it
   // as soon as the checksum byte arrives.
   hsxfp_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hsxfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // The back end keeps the frame counters and drives the result beat.
   hsxfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // A finished frame must never be pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !queue_full)
      else $error("frame pushed into a full queue");

   // Dropped frames carry an all-zero payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_GOOD) |-> (rsp_chan.payload == '0))
      else $error("dropped frame with nonzero payload");

   // Each popped frame advances exactly one of the two counters by one.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> ((rsp_chan.good_frames + rsp_chan.dropped_frames)
               == COUNT_W'($past(rsp_chan.good_frames + rsp_chan.dropped_frames) + 1)))
      else $error("frame counters did not advance by one");

endmodule

>>> sv/hsxfp_front.sv
// Front end: header hunt, frame collection, running XOR and classification.
// Depends on hsxfp_pkg and hsxfp_req_if; pushes finished frames to the queue.
`timescale 1ns / 1ps
module hsxfp_front #(
   parameter int FRAME_BYTES = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hsxfp_pkg::cfg_type         cfg,
   hsxfp_req_if.sink                  req_chan,
   input  logic                       queue_full,
   output logic                       push,
   output hsxfp_pkg::frame_entry_type push_entry
);
   import hsxfp_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] TAIL_POS  = POS_W'(FRAME_BYTES - 2);
   localparam logic [POS_W-1:0] BODY_END  = POS_W'(FRAME_BYTES - 3);
   localparam logic [POS_W-1:0] BODY_POS  = POS_W'(2);

   frame_state_type      state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [BYTE_W-1:0]    xor_ff, xor_in;
   logic                 tail_ok_ff, tail_ok_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                 accept;
   logic [BYTE_W-1:0]    rx;
   logic [SLOT_W-1:0]    slot;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign rx             = req_chan.rx_byte;
   assign slot           = SLOT_W'(pos_ff - BODY_POS);

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      tail_ok_in = tail_ok_ff;
      payload_in = payload_ff;
      push       = 1'b0;
      push_entry.status  = STATUS_GOOD;
      push_entry.payload = payload_ff;
      if (accept) begin
         unique case (state_ff)
            FS_HUNT: begin
               if (rx == cfg.header_first) begin
                  state_in = FS_SYNC;
                  xor_in   = rx;
               end
            end
            FS_SYNC: begin
               if (rx == cfg.header_second) begin
                  state_in   = FS_BODY;
                  pos_in     = BODY_POS;
                  xor_in     = xor_ff ^ rx;
                  tail_ok_in = 1'b0;
                  payload_in = '0;
               end else if (rx == cfg.header_first) begin
                  xor_in = rx;
               end else begin
                  state_in = FS_HUNT;
               end
            end
            FS_BODY: begin
               pos_in = pos_ff + POS_W'(1);
               xor_in = xor_ff ^ rx;
               if (pos_ff <= BODY_END) begin
                  payload_in[slot*BYTE_W +: BYTE_W] = rx;
               end
               if (pos_ff == TAIL_POS) begin
                  tail_ok_in = (rx == cfg.tail_byte);
               end
               if (pos_ff == LAST_POS) begin
                  state_in = FS_HUNT;
                  push     = 1'b1;
                  // Tail is checked before the checksum.
                  if (!tail_ok_ff) begin
                     push_entry.status  = STATUS_TAIL_BAD;
                     push_entry.payload = '0;
                  end else if (xor_ff != rx) begin
                     push_entry.status  = STATUS_XOR_BAD;
                     push_entry.payload = '0;
                  end
               end
            end
            default: state_in = FS_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_HUNT;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
      xor_ff     <= xor_in;
      tail_ok_ff <= tail_ok_in;
      payload_ff <= payload_in;
   end

endmodule

>>> sv/hsxfp_queue.sv
// Short queue of classified frames between the front and back ends.
// Depends on hsxfp_pkg for the entry type and depth.
`timescale 1ns / 1ps
module hsxfp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hsxfp_pkg::frame_entry_type push_entry,
   input  logic                       pop,
   output hsxfp_pkg::frame_entry_type head,
   output logic                       full,
   output logic                       empty
);
   import hsxfp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   frame_entry_type  slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/hsxfp_back.sv
// Back end: frame counters and the registered result beat.
// Depends on hsxfp_pkg and hsxfp_rsp_if; pops entries from the queue.
`timescale 1ns / 1ps
module hsxfp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hsxfp_pkg::frame_entry_type head,
   input  logic                       queue_empty,
   output logic                       pop,
   hsxfp_rsp_if.source                rsp_chan
);
   import hsxfp_pkg::*;

   logic                 valid_ff, valid_in;
   status_type           status_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [COUNT_W-1:0]   good_ff, good_in;
   logic [COUNT_W-1:0]   drop_ff, drop_in;

   assign pop = !queue_empty && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff;
      good_in  = good_ff;
      drop_in  = drop_ff;
      if (pop) begin
         valid_in = 1'b1;
         if (head.status == STATUS_GOOD) begin
            good_in = good_ff + COUNT_W'(1);
         end else begin
            drop_in = drop_ff + COUNT_W'(1);
         end
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         good_ff  <= '0;
         drop_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         good_ff  <= good_in;
         drop_ff  <= drop_in;
      end
      if (pop) begin
         status_ff  <= head.status;
         payload_ff <= head.payload;
      end
   end

   // The counters only move when a beat is loaded, so they double as its fields.
   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.payload        = payload_ff;
   assign rsp_chan.good_frames    = good_ff;
   assign rsp_chan.dropped_frames = drop_ff;

endmodule
